/* design/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types, constants and codes of the first-fit region allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int TABLE_SLOTS     = 256;
    localparam int ALIGN_MASK      = 31;
    localparam int MIN_ALLOC_BYTES = 1;

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 24;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 1;
    localparam int ENTRY_W = ADDR_W + LEN_W;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic [CFG_W-1:0] CFG_REGION_BASE  = 1'd0;
    localparam logic [CFG_W-1:0] CFG_REGION_BYTES = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_A_RD, S_A_EV, S_A_PLACE, S_SU_CHK, S_SU_WR,
        S_F_RD, S_F_EV, S_SD_CHK, S_SD_WR, S_RESP
    } state_t;

    typedef enum logic [1:0] { RD_IDX, RD_JM1, RD_JP1 } rd_sel_t;
    typedef enum logic [1:0] { WR_J, WR_NEW, WR_LEN } wr_sel_t;
    typedef enum logic [1:0] { RES_ZERO, RES_NEW, RES_BLK } res_sel_t;

    typedef struct packed {
        logic              latch_in;
        logic              scan_init;
        logic              scan_next;
        logic              idx_inc;
        logic              j_load_count;
        logic              j_load_idx;
        logic              j_dec;
        logic              j_inc;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_en;
        wr_sel_t           wr_sel;
        logic              count_inc;
        logic              count_dec;
        logic              set_res;
        res_sel_t          res_sel;
        logic [STAT_W-1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             req_small;
        logic             req_zero;
        logic             full;
        logic             size_big;
        logic             idx_at_count;
        logic             fits;
        logic             over_end;
        logic             match;
        logic             j_at_idx;
        logic             jp1_at_count;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/ffra_if.sv */
// ----------------------------------------------------------------------------
// ffra channel interfaces
// request, response and configuration-write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if;
    logic                        valid;
    logic                        ready;
    logic [ffra_pkg::CMD_W-1:0]  cmd;
    logic [ffra_pkg::ADDR_W-1:0] block_address;
    logic [ffra_pkg::LEN_W-1:0]  request_bytes;
    modport source (output valid, cmd, block_address, request_bytes, input ready);
    modport sink (input valid, cmd, block_address, request_bytes, output ready);
endinterface

interface ffra_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ffra_pkg::ADDR_W-1:0] result_address;
    logic [ffra_pkg::STAT_W-1:0] status;
    modport source (output valid, result_address, status, input ready);
    modport sink (input valid, result_address, status, output ready);
endinterface

interface ffra_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ffra_pkg::CFG_W-1:0]  index;
    logic [ffra_pkg::ADDR_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/ffra_datapath.sv */
// ----------------------------------------------------------------------------
// ffra_datapath
// block table memory, scan registers, region registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ffra_pkg::dp_cmd_t           ctl,
    output ffra_pkg::dp_stat_t               stat,
    input  wire logic [ffra_pkg::CMD_W-1:0]  in_cmd,
    input  wire logic [ffra_pkg::ADDR_W-1:0] in_block_address,
    input  wire logic [ffra_pkg::LEN_W-1:0]  in_request_bytes,
    input  wire logic                        cfg_we,
    input  wire logic [ffra_pkg::CFG_W-1:0]  cfg_index,
    input  wire logic [ffra_pkg::ADDR_W-1:0] cfg_data,
    output logic [ffra_pkg::ADDR_W-1:0]      res_address,
    output logic [ffra_pkg::STAT_W-1:0]      res_status
);

    localparam int AW = ffra_pkg::ADDR_W;
    localparam int LW = ffra_pkg::LEN_W;
    localparam int CW = ffra_pkg::CNT_W;
    localparam int IW = ffra_pkg::IDX_W;

    logic [ffra_pkg::ENTRY_W-1:0] mem [ffra_pkg::TABLE_SLOTS];

    logic [AW-1:0] base_reg;
    logic [LW-1:0] bytes_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [ffra_pkg::CMD_W-1:0] cmd_reg;
    logic [AW-1:0] blk_reg;
    logic [LW-1:0] req_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic [AW:0]   scan_reg, scan_next;
    logic [ffra_pkg::ENTRY_W-1:0] rdata_reg;
    logic [AW-1:0] res_addr_reg;
    logic [ffra_pkg::STAT_W-1:0] res_stat_reg;

    logic [LW:0]   size_full;
    logic [LW-1:0] size;
    logic [AW:0]   end_raw, end_clip;
    logic [AW+1:0] scan_sum;
    logic [AW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic [CW-1:0] rd_addr, wr_addr;
    logic [ffra_pkg::ENTRY_W-1:0] wr_data;

    assign size_full = ({1'b0, req_reg} + (LW+1)'(ffra_pkg::ALIGN_MASK))
                       & ~(LW+1)'(ffra_pkg::ALIGN_MASK);
    assign size      = size_full[LW-1:0];
    assign end_raw   = {1'b0, base_reg} + (AW+1)'(bytes_reg);
    // region end clipped to the top of the address space
    assign end_clip  = end_raw[AW] ? {1'b1, {AW{1'b0}}} : end_raw;
    assign scan_sum  = {1'b0, scan_reg} + (AW+2)'(size);
    assign rd_start  = rdata_reg[ffra_pkg::ENTRY_W-1:LW];
    assign rd_len    = rdata_reg[LW-1:0];

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.req_small    = (req_reg < LW'(ffra_pkg::MIN_ALLOC_BYTES));
        stat.req_zero     = (req_reg == '0);
        stat.full         = (count_reg == CW'(ffra_pkg::TABLE_SLOTS));
        stat.size_big     = size_full[LW];
        stat.idx_at_count = (idx_reg == count_reg);
        stat.fits         = (scan_sum <= (AW+2)'(rd_start));
        stat.over_end     = (scan_sum > (AW+2)'(end_clip));
        stat.match        = (rd_start == blk_reg);
        stat.j_at_idx     = (j_reg == idx_reg);
        stat.jp1_at_count = ((j_reg + CW'(1)) == count_reg);
    end

    always_comb
    begin
        case (ctl.rd_sel)
            ffra_pkg::RD_JM1: rd_addr = j_reg - CW'(1);
            ffra_pkg::RD_JP1: rd_addr = j_reg + CW'(1);
            default:          rd_addr = idx_reg;
        endcase
        case (ctl.wr_sel)
            ffra_pkg::WR_NEW:
            begin
                wr_addr = idx_reg;
                wr_data = {scan_reg[AW-1:0], size};
            end
            ffra_pkg::WR_LEN:
            begin
                wr_addr = idx_reg;
                wr_data = {rd_start, size};
            end
            default:
            begin
                wr_addr = j_reg;
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr[IW-1:0]] <= wr_data;
        if (ctl.rd_en)
            rdata_reg <= mem[rd_addr[IW-1:0]];
    end

    always_comb
    begin
        idx_next   = idx_reg;
        scan_next  = scan_reg;
        j_next     = j_reg;
        count_next = count_reg;
        if (ctl.scan_init)
        begin
            idx_next  = '0;
            scan_next = {1'b0, base_reg};
        end
        if (ctl.scan_next)
        begin
            idx_next  = idx_reg + CW'(1);
            scan_next = {1'b0, rd_start} + (AW+1)'(rd_len);
        end
        if (ctl.idx_inc)
            idx_next = idx_reg + CW'(1);
        if (ctl.j_load_count)
            j_next = count_reg;
        if (ctl.j_load_idx)
            j_next = idx_reg;
        if (ctl.j_dec)
            j_next = j_reg - CW'(1);
        if (ctl.j_inc)
            j_next = j_reg + CW'(1);
        if (ctl.count_inc)
            count_next = count_reg + CW'(1);
        if (ctl.count_dec)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we && cfg_index == ffra_pkg::CFG_REGION_BASE)
                base_reg <= cfg_data;
            if (cfg_we && cfg_index == ffra_pkg::CFG_REGION_BYTES)
                bytes_reg <= cfg_data[LW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        scan_reg <= scan_next;
        if (ctl.latch_in)
        begin
            cmd_reg <= in_cmd;
            blk_reg <= in_block_address;
            req_reg <= in_request_bytes;
        end
        if (ctl.set_res)
        begin
            res_stat_reg <= ctl.res_status;
            case (ctl.res_sel)
                ffra_pkg::RES_NEW: res_addr_reg <= scan_reg[AW-1:0];
                ffra_pkg::RES_BLK: res_addr_reg <= blk_reg;
                default:           res_addr_reg <= '0;
            endcase
        end
    end

    assign res_address = res_addr_reg;
    assign res_status  = res_stat_reg;

endmodule

`default_nettype wire

/* design/ffra_ctrl.sv */
// ----------------------------------------------------------------------------
// ffra_ctrl
// sequencer for table scan, insert shift, remove shift and response
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire ffra_pkg::dp_stat_t stat,
    output ffra_pkg::dp_cmd_t       ctl
);

    ffra_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ffra_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = ffra_pkg::RD_IDX;
        ctl.wr_sel = ffra_pkg::WR_J;
        ctl.res_sel = ffra_pkg::RES_ZERO;
        ctl.res_status = ffra_pkg::ST_OK;
        in_ready   = (state_reg == ffra_pkg::S_IDLE);
        out_valid  = (state_reg == ffra_pkg::S_RESP);
        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = ffra_pkg::S_DECODE;
                end
            end
            ffra_pkg::S_DECODE:
            begin
                state_next = ffra_pkg::S_RESP;
                ctl.set_res = 1'b1;
                case (stat.cmd)
                    ffra_pkg::CMD_ALLOC:
                    begin
                        if (stat.req_small)
                            ctl.res_status = ffra_pkg::ST_BAD_SIZE;
                        else if (stat.full)
                            ctl.res_status = ffra_pkg::ST_FULL;
                        else if (stat.size_big)
                            ctl.res_status = ffra_pkg::ST_NO_SPACE;
                        else
                        begin
                            ctl.set_res   = 1'b0;
                            ctl.scan_init = 1'b1;
                            state_next    = ffra_pkg::S_A_RD;
                        end
                    end
                    ffra_pkg::CMD_FREE:
                    begin
                        ctl.set_res   = 1'b0;
                        ctl.scan_init = 1'b1;
                        state_next    = ffra_pkg::S_F_RD;
                    end
                    ffra_pkg::CMD_RESIZE:
                    begin
                        if (stat.req_zero || stat.size_big)
                            ctl.res_status = ffra_pkg::ST_BAD_SIZE;
                        else
                        begin
                            ctl.set_res   = 1'b0;
                            ctl.scan_init = 1'b1;
                            state_next    = ffra_pkg::S_F_RD;
                        end
                    end
                    default: ctl.res_status = ffra_pkg::ST_NOT_FOUND;
                endcase
            end
            ffra_pkg::S_A_RD:
            begin
                if (stat.idx_at_count)
                    state_next = ffra_pkg::S_A_PLACE;
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ffra_pkg::S_A_EV;
                end
            end
            ffra_pkg::S_A_EV:
            begin
                if (stat.fits)
                    state_next = ffra_pkg::S_A_PLACE;
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = ffra_pkg::S_A_RD;
                end
            end
            ffra_pkg::S_A_PLACE:
            begin
                if (stat.over_end)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ffra_pkg::ST_NO_SPACE;
                    state_next     = ffra_pkg::S_RESP;
                end
                else
                begin
                    ctl.j_load_count = 1'b1;
                    state_next       = ffra_pkg::S_SU_CHK;
                end
            end
            // move the tail up one slot, from the top down
            ffra_pkg::S_SU_CHK:
            begin
                if (stat.j_at_idx)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_sel    = ffra_pkg::WR_NEW;
                    ctl.count_inc = 1'b1;
                    ctl.set_res   = 1'b1;
                    ctl.res_sel   = ffra_pkg::RES_NEW;
                    state_next    = ffra_pkg::S_RESP;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = ffra_pkg::RD_JM1;
                    state_next = ffra_pkg::S_SU_WR;
                end
            end
            ffra_pkg::S_SU_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.j_dec  = 1'b1;
                state_next = ffra_pkg::S_SU_CHK;
            end
            ffra_pkg::S_F_RD:
            begin
                if (stat.idx_at_count)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ffra_pkg::ST_NOT_FOUND;
                    state_next     = ffra_pkg::S_RESP;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ffra_pkg::S_F_EV;
                end
            end
            ffra_pkg::S_F_EV:
            begin
                if (!stat.match)
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ffra_pkg::S_F_RD;
                end
                else if (stat.cmd == ffra_pkg::CMD_FREE)
                begin
                    ctl.j_load_idx = 1'b1;
                    state_next     = ffra_pkg::S_SD_CHK;
                end
                else
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_sel  = ffra_pkg::WR_LEN;
                    ctl.set_res = 1'b1;
                    ctl.res_sel = ffra_pkg::RES_BLK;
                    state_next  = ffra_pkg::S_RESP;
                end
            end
            // move the tail down one slot, from the hole upwards
            ffra_pkg::S_SD_CHK:
            begin
                if (stat.jp1_at_count)
                begin
                    ctl.count_dec = 1'b1;
                    ctl.set_res   = 1'b1;
                    state_next    = ffra_pkg::S_RESP;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = ffra_pkg::RD_JP1;
                    state_next = ffra_pkg::S_SD_WR;
                end
            end
            ffra_pkg::S_SD_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.j_inc  = 1'b1;
                state_next = ffra_pkg::S_SD_CHK;
            end
            ffra_pkg::S_RESP:
            begin
                if (out_ready)
                    state_next = ffra_pkg::S_IDLE;
            end
            default: state_next = ffra_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* design/first_fit_region_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// first-fit allocator over a sorted table of allocated blocks
// ----------------------------------------------------------------------------
// channels: req carries cmd (allocate, free, resize), block_address and
// request_bytes; rsp returns result_address and status; cfg writes
// region_base (index 0) and region_bytes (index 1), always ready.
// one request is in flight at a time: req is ready only while the block is
// idle, and the rsp beat is held until taken.
// sequence: a request rejected at decode goes from the decode state straight
// to the response state. a scan reads and evaluates each table entry
// visited, and an insert or a remove moves each entry with a read and a
// write, all through the block table memory with its one read and one write
// port; each live entry is visited at most once and moved at most once.
// reset empties the table at once through a fill count and clears the
// region registers; no clearing pass is needed.
// if rsp stalls, the block simply waits with the result held.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ffra_req_if.sink    req,
    ffra_rsp_if.source  rsp,
    ffra_cfg_if.sink    cfg
);

    ffra_pkg::dp_cmd_t  ctl;
    ffra_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    ffra_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .in_cmd           (req.cmd),
        .in_block_address (req.block_address),
        .in_request_bytes (req.request_bytes),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .res_address      (rsp.result_address),
        .res_status       (rsp.status)
    );

endmodule

`default_nettype wire

/* design/ffra_checker.sv */
// ----------------------------------------------------------------------------
// ffra_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [ffra_pkg::ADDR_W-1:0] result_address,
    input wire logic [ffra_pkg::STAT_W-1:0] status
);

    // stalled response beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_address) && $stable(status))
        else $error("response beat changed under stall");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while response pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("response in the cycle after a request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffra_pkg::ST_OK |-> result_address == '0)
        else $error("failed request with non-zero address");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ffra_pkg::ST_NOT_FOUND)
        else $error("status code out of range");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .result_address (rsp.result_address),
    .status         (rsp.status)
);

`default_nettype wire

/* tb/sv/tb_ffra_if.sv */
// ----------------------------------------------------------------------------
// tb_ffra_if
// request and response item types shared by the testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package tb_ffra_types;

    import ffra_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] block_address;
        logic [LEN_W-1:0]  request_bytes;
    } alloc_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [STAT_W-1:0] status;
    } alloc_rsp_t;

endpackage

/* tb/sv/tb_first_fit_region_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// drives allocate, free, resize and unused-code requests with random gaps and stalls,
// predicts each answer from a private copy of the block table and checks it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_region_allocator;

    import ffra_pkg::*;
    import tb_ffra_types::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4 * TABLE_SLOTS + 16;

    logic clk;
    logic rst_n;

    ffra_req_if req ();
    ffra_rsp_if rsp ();
    ffra_cfg_if cfg ();

    first_fit_region_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // model of the block table
    logic [ADDR_W-1:0] tbl_start [TABLE_SLOTS];
    logic [LEN_W-1:0]  tbl_len   [TABLE_SLOTS];
    logic [ADDR_W-1:0] mdl_base;
    logic [LEN_W-1:0]  mdl_bytes;

    alloc_rsp_t pending_rsp [$];
    int  mismatches;
    bit  hold_rsp;
    int  hold_cycles;
    bit  rsp_gaps_on;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int find_block(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (tbl_len[i] == '0)
                return -1;
            if (tbl_start[i] == addr)
                return i;
        end
        return -1;
    endfunction

    function automatic alloc_rsp_t predict_answer(alloc_req_t r);
        alloc_rsp_t o;
        logic [63:0] size;
        logic [63:0] lim;
        logic [63:0] pos;
        int idx;
        o.result_address = '0;
        o.status = ST_NOT_FOUND;
        case (r.cmd)
            CMD_ALLOC:
            begin
                size = ({40'd0, r.request_bytes} + ALIGN_MASK) & ~64'(ALIGN_MASK);
                lim = {32'd0, mdl_base} + {40'd0, mdl_bytes};
                if (lim > 64'h1_0000_0000)
                    lim = 64'h1_0000_0000;
                pos = {32'd0, mdl_base};
                if (r.request_bytes < MIN_ALLOC_BYTES)
                    o.status = ST_BAD_SIZE;
                else if (tbl_len[TABLE_SLOTS-1] != '0)
                    o.status = ST_FULL;
                else if (size > 64'hFF_FFFF)
                    o.status = ST_NO_SPACE;
                else
                begin
                    o.status = ST_NO_SPACE;
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (tbl_len[i] == '0 || pos + size <= {32'd0, tbl_start[i]})
                        begin
                            if (pos + size <= lim)
                            begin
                                for (int k = TABLE_SLOTS - 1; k > i; k--)
                                begin
                                    tbl_start[k] = tbl_start[k-1];
                                    tbl_len[k] = tbl_len[k-1];
                                end
                                tbl_start[i] = pos[31:0];
                                tbl_len[i] = size[23:0];
                                o.status = ST_OK;
                                o.result_address = pos[31:0];
                            end
                            break;
                        end
                        pos = {32'd0, tbl_start[i]} + {40'd0, tbl_len[i]};
                    end
                end
            end
            CMD_FREE:
            begin
                idx = find_block(r.block_address);
                if (idx >= 0)
                begin
                    for (int k = idx; k < TABLE_SLOTS - 1; k++)
                    begin
                        tbl_start[k] = tbl_start[k+1];
                        tbl_len[k] = tbl_len[k+1];
                    end
                    tbl_start[TABLE_SLOTS-1] = '0;
                    tbl_len[TABLE_SLOTS-1] = '0;
                    o.status = ST_OK;
                end
            end
            CMD_RESIZE:
            begin
                size = ({40'd0, r.request_bytes} + ALIGN_MASK) & ~64'(ALIGN_MASK);
                if (r.request_bytes == '0 || size > 64'hFF_FFFF)
                    o.status = ST_BAD_SIZE;
                else
                begin
                    idx = find_block(r.block_address);
                    if (idx >= 0)
                    begin
                        tbl_len[idx] = size[23:0];
                        o.status = ST_OK;
                        o.result_address = r.block_address;
                    end
                end
            end
            default: o.status = ST_NOT_FOUND;
        endcase
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        alloc_rsp_t exp_rsp;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: addr %h status %0d",
                             rsp.result_address, rsp.status);
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.result_address !== exp_rsp.result_address
                    || rsp.status !== exp_rsp.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr %h status %0d, got addr %h status %0d",
                                 exp_rsp.result_address, exp_rsp.status,
                                 rsp.result_address, rsp.status);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_rsp)
            rsp.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else if (rsp.valid && rsp.ready)
        begin
            hold_cycles <= rsp_gaps_on ? $urandom_range(0, 16) : 0;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // long receiver hold-off counted in cycles
    task automatic hold_receiver(int cycles);
        hold_rsp = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rsp = 1'b0;
    endtask

    task automatic send_request(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                logic [LEN_W-1:0] n, bit gaps);
        alloc_req_t r;
        int gap;
        r.cmd = c;
        r.block_address = a;
        r.request_bytes = n;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // the previous beat has already dropped valid at a falling edge
        repeat ((gap == 0) ? 1 : gap) @(negedge clk);
        req.valid <= 1'b1;
        req.cmd <= c;
        req.block_address <= a;
        req.request_bytes <= n;
        do
            @(posedge clk);
        while (!req.ready);
        pending_rsp.push_back(predict_answer(r));
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_W-1:0] index, logic [ADDR_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (index == CFG_REGION_BASE)
            mdl_base = value;
        else
            mdl_bytes = value[LEN_W-1:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_region(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] bytes);
        wait_idle();
        write_register(CFG_REGION_BASE, base);
        @(negedge clk);
        write_register(CFG_REGION_BYTES, {{(ADDR_W-LEN_W){1'b0}}, bytes});
    endtask

    // an address that names a live block most of the time
    function automatic logic [ADDR_W-1:0] pick_address();
        int used;
        used = 0;
        while (used < TABLE_SLOTS && tbl_len[used] != '0)
            used++;
        if (used != 0 && $urandom_range(0, 9) < 8)
            return tbl_start[$urandom_range(0, used - 1)];
        return $urandom();
    endfunction

    function automatic logic [LEN_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return LEN_W'($urandom());
            1: return LEN_W'(32'hFF_FFE0 + $urandom_range(0, 31));
            2: return 24'd0;
            default: return LEN_W'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic test_directed();
        set_region(32'h0000_1000, 24'h00_0200);
        send_request(CMD_ALLOC, '0, 24'd0, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd1, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd32, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd33, 1'b0);
        send_request(CMD_ALLOC, '0, 24'hFF_FFFF, 1'b0);
        send_request(CMD_ALLOC, '0, 24'hFF_FFE0, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd1000, 1'b0);
        send_request(CMD_FREE, 32'h0000_1020, '0, 1'b0);
        send_request(CMD_FREE, 32'hFFFF_FFFF, '0, 1'b0);
        send_request(CMD_RESIZE, 32'h0000_1000, 24'd0, 1'b0);
        send_request(CMD_RESIZE, 32'h0000_1000, 24'hFF_FFFF, 1'b0);
        send_request(CMD_RESIZE, 32'h0000_1000, 24'd64, 1'b0);
        send_request(CMD_RESIZE, 32'h0000_5555, 24'd64, 1'b0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd16, 1'b0);
        // region running off the end of the address space, block at zero
        set_region(32'hFFFF_FF00, 24'hFF_FFFF);
        send_request(CMD_ALLOC, '0, 24'd200, 1'b0);
        send_request(CMD_ALLOC, '0, 24'd64, 1'b0);
        set_region(32'h0000_0000, 24'h00_0100);
        send_request(CMD_ALLOC, '0, 24'd32, 1'b0);
        send_request(CMD_FREE, 32'h0000_0000, '0, 1'b0);
        send_request(CMD_FREE, 32'h0000_1000, '0, 1'b0);
    endtask

    task automatic test_full_table();
        set_region(32'h8000_0000, 24'hFF_FFFF);
        for (int i = 0; i < TABLE_SLOTS + 2; i++)
            send_request(CMD_ALLOC, '0, 24'd1, 1'b0);
        send_request(CMD_ALLOC, '0, 24'hFF_FFFF, 1'b0);
        for (int i = 0; i < 20; i++)
            send_request(CMD_FREE, pick_address(), '0, 1'b0);
    endtask

    task automatic test_random(int count, bit gaps);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send_request(CMD_ALLOC, $urandom(), pick_size(), gaps);
            else if (pick < 14)
                send_request(CMD_FREE, pick_address(), LEN_W'($urandom()), gaps);
            else if (pick < 19)
                send_request(CMD_RESIZE, pick_address(), pick_size(), gaps);
            else
                send_request(CMD_UNUSED, $urandom(), LEN_W'($urandom()), gaps);
        end
    endtask

    task automatic test_backpressure();
        fork
            hold_receiver(400);
            test_random(6, 1'b0);
        join
        // sender waits for every answer before going on
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
        test_random(4, 1'b1);
    endtask

    initial begin
        mismatches = 0;
        hold_rsp = 1'b0;
        hold_cycles = 0;
        rsp_gaps_on = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = '0;
        req.block_address = '0;
        req.request_bytes = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rsp.ready = 1'b0;
        mdl_base = '0;
        mdl_bytes = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_start[i] = '0;
            tbl_len[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        rsp_gaps_on = 1'b1;
        test_full_table();
        set_region(32'h0010_0000, 24'h00_2000);
        test_random(100, 1'b1);
        test_backpressure();
        set_region(32'hFFFF_F000, 24'hFF_FFFF);
        test_random(250, 1'b1);
        rsp_gaps_on = 1'b0;
        set_region(32'h4000_0000, 24'h01_0000);
        test_random(250, 1'b0);
        rsp_gaps_on = 1'b1;
        set_region(32'h0000_0000, 24'h00_0000);
        test_random(30, 1'b1);
        set_region($urandom(), LEN_W'($urandom()));
        test_random(250, 1'b1);

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
design/ffra_pkg.sv
design/ffra_if.sv
design/ffra_datapath.sv
design/ffra_ctrl.sv
design/first_fit_region_allocator.sv
design/ffra_checker.sv
tb/sv/tb_ffra_if.sv
tb/sv/tb_first_fit_region_allocator.sv
